### design/mpq_pkg.sv
// Shared types and constants for the min priority queue.
package mpq_pkg;
    localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_code_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] new_key;
    } mpq_in_t;

    typedef struct packed {
        logic signed [31:0] min_key;
        logic               is_empty;
        logic               is_full;
        logic               dropped;
    } mpq_out_t;

    typedef struct packed {
        logic               is_insert;
        logic               is_remove;
        logic signed [31:0] key;
    } mpq_op_t;
endpackage

### design/mpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### design/mpq_front.sv
// Command front end: accepts commands, classifies them, feeds a one-entry queue.
module mpq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mpq_pkg::mpq_in_t cmd_in,
    output logic            busy,
    output logic            op_valid,
    output mpq_pkg::mpq_op_t op,
    input  logic            op_take,
    input  logic            back_done
);
    import mpq_pkg::*;

    logic    op_valid_reg, op_valid_next;
    mpq_op_t op_reg, op_next;
    logic    pend_reg, pend_next;

    always_comb
    begin
        op_valid_next = op_valid_reg;
        op_next       = op_reg;
        pend_next     = pend_reg;
        if (op_take)
        begin
            op_valid_next = 1'b0;
        end
        if (back_done)
        begin
            pend_next = 1'b0;
        end
        if (start && !busy)
        begin
            op_valid_next      = 1'b1;
            pend_next          = 1'b1;
            op_next.is_insert  = (cmd_in.command == CMD_INSERT);
            op_next.is_remove  = (cmd_in.command == CMD_REMOVE);
            op_next.key        = cmd_in.new_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            op_reg       <= '0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
            pend_reg     <= pend_next;
            op_reg       <= op_next;
        end
    end

    assign busy     = pend_reg;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;
endmodule

### design/mpq_back.sv
// Execution engine: applies commands to the key store and scans for the minimum.
module mpq_back #(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    input  mpq_pkg::mpq_op_t op,
    output logic             op_take,
    output logic             done,
    output logic             result_valid,
    output mpq_pkg::mpq_out_t result
);
    import mpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_MOVE_RD, S_MOVE_WR, S_SCAN, S_SCAN_LAST, S_REPORT
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      best_idx_reg;
    logic signed [31:0] best_reg;
    logic               dropped_reg;
    logic               min_valid_reg;
    logic [AW-1:0]      min_idx_reg;
    logic signed [31:0] min_reg;
    logic               res_valid_reg;
    mpq_out_t           res_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;

    mpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [AW-1:0] last_idx;
    assign last_idx = AW'(count_reg - CW'(1));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(count_reg);
        wr_data = op.key;
        rd_addr = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid && op.is_insert && count_reg != CAP)
                begin
                    wr_en = 1'b1;
                end
                rd_addr = last_idx;
            end
            S_MOVE_RD:
            begin
                wr_en   = 1'b1;
                wr_addr = min_idx_reg;
                wr_data = rd_data;
            end
            S_MOVE_WR:
            begin
                rd_addr = '0;
            end
            default: rd_addr = idx_reg;
        endcase
    end

    assign op_take = (state_reg == S_IDLE) && op_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            best_idx_reg  <= '0;
            best_reg      <= EMPTY_MIN;
            dropped_reg   <= 1'b0;
            min_valid_reg <= 1'b0;
            min_idx_reg   <= '0;
            min_reg       <= EMPTY_MIN;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (op_valid)
                    begin
                        dropped_reg <= 1'b0;
                        priority if (op.is_insert)
                        begin
                            if (count_reg == CAP)
                            begin
                                dropped_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + CW'(1);
                                if (count_reg == '0 || op.key < min_reg)
                                begin
                                    min_reg     <= op.key;
                                    min_idx_reg <= AW'(count_reg);
                                end
                            end
                            state_reg <= S_REPORT;
                        end
                        else if (op.is_remove && count_reg != '0)
                        begin
                            state_reg <= S_MOVE_RD;
                        end
                        else
                        begin
                            state_reg <= S_REPORT;
                        end
                    end
                end
                S_MOVE_RD:
                begin
                    // read of last entry issued in S_IDLE is now in rd_data
                    state_reg <= S_MOVE_WR;
                end
                S_MOVE_WR:
                begin
                    count_reg <= count_reg - CW'(1);
                    idx_reg   <= (last_idx == '0) ? '0 : AW'(1);
                    best_reg  <= EMPTY_MIN;
                    best_idx_reg <= '0;
                    if (last_idx == '0)
                    begin
                        min_reg   <= EMPTY_MIN;
                        state_reg <= S_REPORT;
                    end
                    else if (last_idx == AW'(1))
                    begin
                        state_reg <= S_SCAN_LAST;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // rd_data holds entry idx_reg-1
                    if (idx_reg == AW'(1) || $signed(rd_data) < best_reg)
                    begin
                        best_reg     <= rd_data;
                        best_idx_reg <= idx_reg - AW'(1);
                    end
                    if (idx_reg == last_idx)
                    begin
                        state_reg <= S_SCAN_LAST;
                    end
                    idx_reg <= idx_reg + AW'(1);
                end
                S_SCAN_LAST:
                begin
                    if (idx_reg == AW'(1) || $signed(rd_data) < best_reg)
                    begin
                        min_reg     <= rd_data;
                        min_idx_reg <= idx_reg - AW'(1);
                    end
                    else
                    begin
                        min_reg     <= best_reg;
                        min_idx_reg <= best_idx_reg;
                    end
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    res_valid_reg    <= 1'b1;
                    res_reg.min_key  <= (count_reg == '0) ? EMPTY_MIN : min_reg;
                    res_reg.is_empty <= (count_reg == '0);
                    res_reg.is_full  <= (count_reg == CAP);
                    res_reg.dropped  <= dropped_reg;
                    state_reg        <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done         = res_valid_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
endmodule

### design/min_priority_queue_core.sv
// Top level of the bounded min priority queue.
// Usage: drive command_in with start while busy is low; that edge is the
// transfer. busy then stays high until the result has been shown.
// Each command yields one result on result with valid high for one cycle;
// the receiver cannot stall and must take it then.
// Insert, status and remove on an empty queue need no scan; any other
// remove finds the new minimum by a linear scan of the key store through
// its single registered read port, one entry per cycle.
// The current minimum and its slot are held in registers, so inserts need
// no scan. Insert into a full queue is refused and flagged as dropped;
// remove on an empty queue leaves it unchanged.
// Reset empties the queue; store contents are left as they are and never
// used beyond the count. No clearing pass is needed.
// A new command is accepted the cycle after the previous result strobe.
module min_priority_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mpq_pkg::mpq_in_t  command_in,
    output logic              busy,
    output logic              valid,
    output mpq_pkg::mpq_out_t result
);
    import mpq_pkg::*;

    logic    op_valid;
    mpq_op_t op;
    logic    op_take;
    logic    done;

    mpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd_in    (command_in),
        .busy      (busy),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take),
        .back_done (done)
    );

    mpq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op           (op),
        .op_take      (op_take),
        .done         (done),
        .result_valid (valid),
        .result       (result)
    );
endmodule

### design/mpq_checker.sv
// Port-level assertions for the min priority queue, bound to the top level.
module mpq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              valid,
    input mpq_pkg::mpq_out_t result
);
    import mpq_pkg::*;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("no busy after transfer");
    a_valid_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !busy) else $error("busy after result");
    a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.is_empty |-> result.min_key == EMPTY_MIN)
        else $error("empty with key");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !(result.is_empty && result.is_full)) else $error("empty and full");
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result without command");
endmodule

bind min_priority_queue_core mpq_checker u_mpq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .valid  (valid),
    .result (result)
);

### test/tb_min_priority_queue_core.sv
// Self-checking testbench for the min priority queue core: directed table, fill and drain, plus random commands.
module tb_min_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import mpq_pkg::*;

    localparam int CAP = 64;

    typedef struct {
        cmd_code_t          cmd;
        logic signed [31:0] key;
        bit                 has_exp;
        mpq_out_t           exp;
    } row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    mpq_in_t  command_in;
    logic     busy;
    logic     valid;
    mpq_out_t result;

    logic signed [31:0] held_keys[$];
    mpq_out_t           pending[$];
    int                 mismatches;
    int                 n_results;
    int                 n_dropped;
    int                 n_full;
    int                 n_cmds;

    min_priority_queue_core #(.CAPACITY(CAP)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .command_in(command_in),
        .busy(busy), .valid(valid), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic mpq_out_t apply_command(cmd_code_t cmd, logic signed [31:0] key);
        mpq_out_t r;
        int       m;
        r = '0;
        if (cmd == CMD_INSERT)
        begin
            if (held_keys.size() >= CAP)
                r.dropped = 1'b1;
            else
                held_keys.push_back(key);
        end
        else if (cmd == CMD_REMOVE && held_keys.size() > 0)
        begin
            m = 0;
            foreach (held_keys[i])
                if (held_keys[i] < held_keys[m])
                    m = i;
            held_keys.delete(m);
        end
        r.min_key = EMPTY_MIN;
        foreach (held_keys[i])
            if (held_keys[i] < r.min_key)
                r.min_key = held_keys[i];
        r.is_empty = (held_keys.size() == 0);
        r.is_full  = (held_keys.size() == CAP);
        return r;
    endfunction

    task automatic send(cmd_code_t cmd, logic signed [31:0] key, int gap);
        repeat (gap) @(posedge clk);
        start      <= 1'b1;
        command_in <= '{command: cmd, new_key: key};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending.push_back(apply_command(cmd, key));
        n_cmds++;
        start      <= 1'b0;
        command_in <= '{command: CMD_STATUS, new_key: $urandom};
        @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        mpq_out_t e;
        if (rst_n && valid)
        begin
            n_results++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", result);
            end
            else
            begin
                e = pending.pop_front();
                if (result.dropped)
                    n_dropped++;
                if (result.is_full)
                    n_full++;
                if (result.min_key !== e.min_key || result.is_empty !== e.is_empty
                    || result.is_full !== e.is_full || result.dropped !== e.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: min %0d/%0d empty %b/%b full %b/%b drop %b/%b",
                            e.min_key, result.min_key, e.is_empty, result.is_empty,
                            e.is_full, result.is_full, e.dropped, result.dropped);
                end
            end
        end
    end

    initial
    begin
        #8ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        row_t               table_rows[$];
        cmd_code_t          cmd;
        logic signed [31:0] key;
        int                 r;
        int                 limit;
        mismatches = 0;
        n_results  = 0;
        n_dropped  = 0;
        n_full     = 0;
        n_cmds     = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        command_in = '{command: CMD_STATUS, new_key: 32'sd0};
        table_rows = '{
            '{CMD_STATUS, 32'sd0, 1, '{EMPTY_MIN, 1'b1, 1'b0, 1'b0}},
            '{CMD_REMOVE, 32'sd5, 1, '{EMPTY_MIN, 1'b1, 1'b0, 1'b0}},
            '{CMD_UNUSED, -32'sd1, 1, '{EMPTY_MIN, 1'b1, 1'b0, 1'b0}},
            '{CMD_INSERT, 32'sh7FFF_FFFF, 1, '{EMPTY_MIN, 1'b0, 1'b0, 1'b0}},
            '{CMD_INSERT, 32'sh8000_0000, 1, '{32'sh8000_0000, 1'b0, 1'b0, 1'b0}},
            '{CMD_INSERT, 32'sh8000_0000, 0, '0},
            '{CMD_INSERT, -32'sd1, 0, '0},
            '{CMD_INSERT, 32'sd0, 0, '0},
            '{CMD_REMOVE, 32'sd0, 0, '0},
            '{CMD_REMOVE, 32'sd0, 0, '0},
            '{CMD_REMOVE, 32'sd0, 0, '0},
            '{CMD_STATUS, 32'sd0, 0, '0},
            '{CMD_REMOVE, 32'sd0, 0, '0},
            '{CMD_REMOVE, 32'sd0, 1, '{EMPTY_MIN, 1'b1, 1'b0, 1'b0}}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
        begin
            send(table_rows[i].cmd, table_rows[i].key, pick_gap());
            if (table_rows[i].has_exp)
                pending[$] = table_rows[i].exp;
        end
        // fill to capacity, overflow, then drain
        for (int i = 0; i < CAP + 3; i++)
            send(CMD_INSERT, $urandom, i < 20 ? pick_gap() : 0);
        while (pending.size() != 0)
            @(posedge clk);
        for (int i = 0; i < CAP + 2; i++)
            send(CMD_REMOVE, 32'sd0, pick_gap());
        for (int i = 0; i < 800; i++)
        begin
            r = $urandom_range(0, 99);
            limit = (i / 150) % 2 ? 55 : 35;
            if (r < limit)
                cmd = CMD_INSERT;
            else if (r < 90)
                cmd = CMD_REMOVE;
            else if (r < 96)
                cmd = CMD_STATUS;
            else
                cmd = CMD_UNUSED;
            r = $urandom_range(0, 9);
            if (r == 0)
                key = 32'sh7FFF_FFFF;
            else if (r == 1)
                key = 32'sh8000_0000;
            else if (r < 4)
                key = $urandom_range(0, 7) - 4;
            else
                key = $urandom;
            send(cmd, key, pick_gap());
            if (i % 300 == 299)
                while (pending.size() != 0)
                    @(posedge clk);
        end
        while (pending.size() != 0)
            @(posedge clk);
        repeat (CAP + 10) @(posedge clk);
        $display("Covered %0d commands, %0d results, %0d refused inserts, %0d full reports.",
            n_cmds, n_results, n_dropped, n_full);
        if (mismatches == 0 && pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### files.f
design/mpq_pkg.sv
design/mpq_ram.sv
design/mpq_front.sv
design/mpq_back.sv
design/min_priority_queue_core.sv
design/mpq_checker.sv
test/tb_min_priority_queue_core.sv
